FILE: rtl/core/iprtm_pkg.sv
// ----------------------------------------------------------------------------
// iprtm_pkg
// Shared types, codes and helpers of the IPv4 rule table match core.
// ----------------------------------------------------------------------------
`default_nettype none

package iprtm_pkg;

    // stream payload widths
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 48;
    localparam int ADDR_W      = 32;
    localparam int PREFIX_W    = 6;
    localparam int CFG_INDEX_W = 1;

    localparam logic [PREFIX_W-1:0] PREFIX_HOST = 6'd32;

    // request kinds, carried on the input tuser
    typedef logic [1:0] req_t;
    localparam req_t REQ_INSERT = 2'd0;
    localparam req_t REQ_FIRST  = 2'd1;
    localparam req_t REQ_ALL    = 2'd2;

    // result status codes
    typedef logic [1:0] status_t;
    localparam status_t STAT_OK      = 2'd0;
    localparam status_t STAT_DUP_IGN = 2'd1;
    localparam status_t STAT_DUP_ERR = 2'd2;
    localparam status_t STAT_FULL    = 2'd3;

    // verdict codes
    typedef logic [1:0] verdict_t;
    localparam verdict_t VERD_NONE    = 2'd0;
    localparam verdict_t VERD_POS     = 2'd1;
    localparam verdict_t VERD_NEITHER = 2'd3;

    // rule action codes
    typedef logic [1:0] action_t;
    localparam action_t ACT_POS = 2'd0;
    localparam action_t ACT_ODD = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REJECT = 1'b1;

    typedef struct packed {
        action_t             action;
        logic [ADDR_W-1:0]   addr;
    } host_entry_t;

    typedef struct packed {
        action_t             action;
        logic [PREFIX_W-1:0] prefix;
        logic [ADDR_W-1:0]   addr;
    } net_entry_t;

    // table port strobes from the sequencer
    typedef struct packed {
        logic host_rd;
        logic host_wr;
        logic net_rd;
        logic net_wr;
    } tbl_ctrl_t;

    // top prefix bits set; prefix expected in 0..32
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] p);
        logic [ADDR_W-1:0] m;
        if (p == '0)
            m = '0;
        else
            m = {ADDR_W{1'b1}} << (PREFIX_HOST - p);
        return m;
    endfunction

    function automatic verdict_t verdict_of(input action_t act);
        verdict_t v;
        if (act == ACT_ODD)
            v = VERD_NEITHER;
        else
            v = verdict_t'(act + 2'd1);
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ip_rule_table_match_core.sv
// ----------------------------------------------------------------------------
// ip_rule_table_match_core
// IPv4 rule table: insert with duplicate check, first-match and collect-all
// lookups over a host store and a network store.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | contents
//  s_axis   | in        | tvalid / tready         | request item
//  m_axis   | out       | tvalid / tready / tlast | result items
//  cfg      | in        | cfg_we                  | enable, reject_duplicates
//
//  An insert walks the target store for a duplicate; a lookup of an enabled,
//  non-empty table walks the host store, then the network store, one read per
//  cycle of each rule memory. A new request is taken only when the sequencer is
//  idle; a result waiting in the output register does not block it. Output
//  backpressure holds a walk in place. Reset empties both stores at once.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_rule_table_match_core #(
    parameter int HOST_ENTRIES = 64,
    parameter int NET_ENTRIES  = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // address [31:0], prefix_len [37:32], rule_action [39:38]
    input  wire logic [iprtm_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // req_type [1:0]
    input  wire logic [1:0]                          s_axis_tuser,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // status [1:0], verdict [3:2], matched_network [35:4],
    // matched_prefix [41:36], zero [47:42]
    output logic [iprtm_pkg::M_TDATA_W-1:0]          m_axis_tdata,
    output logic                                     m_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic                                cfg_we,
    input  wire logic [iprtm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic                                cfg_data
);
    import iprtm_pkg::*;

    localparam int HCNT_W = $clog2(HOST_ENTRIES + 1);
    localparam int NCNT_W = $clog2(NET_ENTRIES + 1);
    localparam int HIDX_W = $clog2(HOST_ENTRIES > 1 ? HOST_ENTRIES : 2);
    localparam int NIDX_W = $clog2(NET_ENTRIES > 1 ? NET_ENTRIES : 2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HSCAN,
        ST_NSCAN,
        ST_FINISH
    } state_t;

    // control state
    state_t              state_reg, state_next;
    req_t                kind_reg, kind_next;
    logic                ins_host_reg, ins_host_next;
    logic                dup_reg, dup_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                e_valid_reg, e_valid_next;
    logic [HCNT_W-1:0]   host_idx_reg, host_idx_next;
    logic [NCNT_W-1:0]   net_idx_reg, net_idx_next;
    logic [HCNT_W-1:0]   host_used_reg, host_used_next;
    logic [NCNT_W-1:0]   net_used_reg, net_used_next;
    logic                enable_reg, reject_reg;
    logic                out_valid_reg, out_valid_next;

    // payload
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [PREFIX_W-1:0] pre_reg, pre_next;
    action_t             act_reg, act_next;
    logic [ADDR_W-1:0]   pend_net_reg, pend_net_next;
    logic [PREFIX_W-1:0] pend_pre_reg, pend_pre_next;
    status_t             ostat_reg, ostat_next;
    verdict_t            overd_reg, overd_next;
    logic [ADDR_W-1:0]   onet_reg, onet_next;
    logic [PREFIX_W-1:0] opre_reg, opre_next;
    logic                olast_reg, olast_next;

    // input fields
    logic [ADDR_W-1:0]   in_addr;
    logic [PREFIX_W-1:0] in_pre;
    action_t             in_act;
    logic [PREFIX_W-1:0] pre_sat;

    // table interface
    tbl_ctrl_t           tctl;
    host_entry_t         hd, host_wr_data;
    net_entry_t          nd, net_wr_data;
    logic [NCNT_W-1:0]   net_dec;

    // datapath helpers
    logic                can_emit;
    logic                h_hit, n_match, n_dup;
    logic                stall, stop;
    logic                emit;
    status_t             e_stat, ins_stat;
    verdict_t            e_verd;
    logic [ADDR_W-1:0]   e_net;
    logic [PREFIX_W-1:0] e_pre;
    logic                e_last;
    logic                full;

    assign in_addr = s_axis_tdata[31:0];
    assign in_pre  = s_axis_tdata[37:32];
    assign in_act  = s_axis_tdata[39:38];
    assign pre_sat = (in_pre > PREFIX_HOST) ? PREFIX_HOST : in_pre;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign can_emit      = !out_valid_reg || m_axis_tready;

    assign net_dec      = net_idx_reg - NCNT_W'(1);
    assign host_wr_data = '{action: act_reg, addr: addr_reg};
    assign net_wr_data  = '{action: act_reg, prefix: pre_reg, addr: addr_reg};

    iprtm_tables #(
        .HOST_ENTRIES (HOST_ENTRIES),
        .NET_ENTRIES  (NET_ENTRIES)
    ) u_tables (
        .clk          (clk),
        .ctl          (tctl),
        .host_rd_addr (host_idx_reg[HIDX_W-1:0]),
        .host_wr_addr (host_used_reg[HIDX_W-1:0]),
        .host_wr_data (host_wr_data),
        .host_rd_data (hd),
        .net_rd_addr  (net_dec[NIDX_W-1:0]),
        .net_wr_addr  (net_used_reg[NIDX_W-1:0]),
        .net_wr_data  (net_wr_data),
        .net_rd_data  (nd)
    );

    // compares on the most recently read entry
    assign h_hit   = (hd.addr == addr_reg);
    assign n_match = ((addr_reg & prefix_mask(nd.prefix)) == nd.addr);
    assign n_dup   = (nd.addr == addr_reg) && (nd.prefix == pre_reg);

    // insert outcome
    assign full = ins_host_reg ? (host_used_reg == HCNT_W'(HOST_ENTRIES))
                               : (net_used_reg == NCNT_W'(NET_ENTRIES));
    always_comb
    begin
        if (dup_reg)
            ins_stat = reject_reg ? STAT_DUP_ERR : STAT_DUP_IGN;
        else if (full)
            ins_stat = STAT_FULL;
        else
            ins_stat = STAT_OK;
    end

    // sequencer: walk the stores one read a cycle while the output does not stall
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        ins_host_next   = ins_host_reg;
        dup_next        = dup_reg;
        pend_valid_next = pend_valid_reg;
        e_valid_next    = e_valid_reg;
        host_idx_next   = host_idx_reg;
        net_idx_next    = net_idx_reg;
        host_used_next  = host_used_reg;
        net_used_next   = net_used_reg;
        addr_next       = addr_reg;
        pre_next        = pre_reg;
        act_next        = act_reg;
        pend_net_next   = pend_net_reg;
        pend_pre_next   = pend_pre_reg;
        tctl            = '0;
        stall           = 1'b0;
        stop            = 1'b0;
        emit            = 1'b0;
        e_stat          = STAT_OK;
        e_verd          = VERD_NONE;
        e_net           = '0;
        e_pre           = '0;
        e_last          = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    case (s_axis_tuser)
                        REQ_INSERT:
                        begin
                            kind_next     = REQ_INSERT;
                            addr_next     = in_addr & prefix_mask(pre_sat);
                            pre_next      = pre_sat;
                            act_next      = in_act;
                            dup_next      = 1'b0;
                            ins_host_next = (pre_sat == PREFIX_HOST);
                            host_idx_next = '0;
                            net_idx_next  = net_used_reg;
                            e_valid_next  = 1'b0;
                            state_next    = (pre_sat == PREFIX_HOST) ? ST_HSCAN : ST_NSCAN;
                        end
                        REQ_FIRST, REQ_ALL:
                        begin
                            kind_next       = s_axis_tuser;
                            addr_next       = in_addr;
                            pend_valid_next = 1'b0;
                            host_idx_next   = '0;
                            net_idx_next    = net_used_reg;
                            e_valid_next    = 1'b0;
                            if (!enable_reg || (host_used_reg == '0 && net_used_reg == '0))
                                state_next = ST_FINISH;
                            else
                                state_next = ST_HSCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_HSCAN:
            begin
                if (e_valid_reg)
                begin
                    case (kind_reg)
                        REQ_INSERT:
                        begin
                            if (h_hit)
                            begin
                                dup_next = 1'b1;
                                stop     = 1'b1;
                            end
                        end
                        REQ_FIRST:
                        begin
                            if (h_hit)
                            begin
                                if (can_emit)
                                begin
                                    emit   = 1'b1;
                                    e_verd = verdict_of(hd.action);
                                    e_net  = addr_reg;
                                    e_pre  = PREFIX_HOST;
                                    stop   = 1'b1;
                                end
                                else
                                    stall = 1'b1;
                            end
                        end
                        REQ_ALL:
                        begin
                            if (h_hit && hd.action == ACT_POS && !pend_valid_reg)
                            begin
                                pend_valid_next = 1'b1;
                                pend_net_next   = addr_reg;
                                pend_pre_next   = PREFIX_HOST;
                            end
                        end
                        default:
                        begin
                            stop = 1'b1;
                        end
                    endcase
                end
                if (stop)
                begin
                    e_valid_next = 1'b0;
                    state_next   = (kind_reg == REQ_FIRST) ? ST_IDLE : ST_FINISH;
                end
                else if (!stall)
                begin
                    if (host_idx_reg < host_used_reg)
                    begin
                        tctl.host_rd  = 1'b1;
                        host_idx_next = host_idx_reg + HCNT_W'(1);
                        e_valid_next  = 1'b1;
                    end
                    else
                    begin
                        e_valid_next = 1'b0;
                        if (!e_valid_reg)
                            state_next = (kind_reg == REQ_INSERT) ? ST_FINISH : ST_NSCAN;
                    end
                end
            end

            ST_NSCAN:
            begin
                if (e_valid_reg)
                begin
                    case (kind_reg)
                        REQ_INSERT:
                        begin
                            if (n_dup)
                            begin
                                dup_next = 1'b1;
                                stop     = 1'b1;
                            end
                        end
                        REQ_FIRST:
                        begin
                            if (n_match)
                            begin
                                if (can_emit)
                                begin
                                    emit   = 1'b1;
                                    e_verd = verdict_of(nd.action);
                                    e_net  = nd.addr;
                                    e_pre  = nd.prefix;
                                    stop   = 1'b1;
                                end
                                else
                                    stall = 1'b1;
                            end
                        end
                        REQ_ALL:
                        begin
                            if (n_match && nd.action == ACT_POS)
                            begin
                                // the held match goes out once a newer one exists
                                if (pend_valid_reg)
                                begin
                                    if (can_emit)
                                    begin
                                        emit          = 1'b1;
                                        e_verd        = VERD_POS;
                                        e_net         = pend_net_reg;
                                        e_pre         = pend_pre_reg;
                                        e_last        = 1'b0;
                                        pend_net_next = nd.addr;
                                        pend_pre_next = nd.prefix;
                                    end
                                    else
                                        stall = 1'b1;
                                end
                                else
                                begin
                                    pend_valid_next = 1'b1;
                                    pend_net_next   = nd.addr;
                                    pend_pre_next   = nd.prefix;
                                end
                            end
                        end
                        default:
                        begin
                            stop = 1'b1;
                        end
                    endcase
                end
                if (stop)
                begin
                    e_valid_next = 1'b0;
                    state_next   = (kind_reg == REQ_FIRST) ? ST_IDLE : ST_FINISH;
                end
                else if (!stall)
                begin
                    if (net_idx_reg != '0)
                    begin
                        tctl.net_rd  = 1'b1;
                        net_idx_next = net_dec;
                        e_valid_next = 1'b1;
                    end
                    else
                    begin
                        e_valid_next = 1'b0;
                        if (!e_valid_reg)
                            state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    if (kind_reg == REQ_INSERT)
                    begin
                        e_stat = ins_stat;
                        e_net  = addr_reg;
                        e_pre  = pre_reg;
                        if (ins_stat == STAT_OK)
                        begin
                            if (ins_host_reg)
                            begin
                                tctl.host_wr   = 1'b1;
                                host_used_next = host_used_reg + HCNT_W'(1);
                            end
                            else
                            begin
                                tctl.net_wr   = 1'b1;
                                net_used_next = net_used_reg + NCNT_W'(1);
                            end
                        end
                    end
                    else if (pend_valid_reg)
                    begin
                        e_verd          = VERD_POS;
                        e_net           = pend_net_reg;
                        e_pre           = pend_pre_reg;
                        pend_valid_next = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        ostat_next     = ostat_reg;
        overd_next     = overd_reg;
        onet_next      = onet_reg;
        opre_next      = opre_reg;
        olast_next     = olast_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            ostat_next     = e_stat;
            overd_next     = e_verd;
            onet_next      = e_net;
            opre_next      = e_pre;
            olast_next     = e_last;
        end
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            kind_reg       <= REQ_INSERT;
            ins_host_reg   <= 1'b0;
            dup_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            e_valid_reg    <= 1'b0;
            host_idx_reg   <= '0;
            net_idx_reg    <= '0;
            host_used_reg  <= '0;
            net_used_reg   <= '0;
            enable_reg     <= 1'b1;
            reject_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            ins_host_reg   <= ins_host_next;
            dup_reg        <= dup_next;
            pend_valid_reg <= pend_valid_next;
            e_valid_reg    <= e_valid_next;
            host_idx_reg   <= host_idx_next;
            net_idx_reg    <= net_idx_next;
            host_used_reg  <= host_used_next;
            net_used_reg   <= net_used_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ENABLE: enable_reg <= cfg_data;
                    CFG_REJECT: reject_reg <= cfg_data;
                    default:    enable_reg <= enable_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        pre_reg      <= pre_next;
        act_reg      <= act_next;
        pend_net_reg <= pend_net_next;
        pend_pre_reg <= pend_pre_next;
        ostat_reg    <= ostat_next;
        overd_reg    <= overd_next;
        onet_reg     <= onet_next;
        opre_reg     <= opre_next;
        olast_reg    <= olast_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - 42){1'b0}}, opre_reg, onet_reg, overd_reg, ostat_reg};

`ifndef NO_ASSERTIONS
    // no read in flight while waiting for a request
    a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !e_valid_reg)
        else $error("read in flight while idle");

    // fill counts stay within the stores
    a_host_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (host_used_reg <= HCNT_W'(HOST_ENTRIES)) && (net_used_reg <= NCNT_W'(NET_ENTRIES)))
        else $error("fill count beyond store depth");

    // a held match belongs to a collect-all walk
    a_pend_kind: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (kind_reg == REQ_ALL))
        else $error("held match outside collect-all");

    // stores are written only when the insert result goes out
    a_write_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (tctl.host_wr || tctl.net_wr) |-> (state_reg == ST_FINISH) && can_emit)
        else $error("table write outside insert completion");

    // a new host entry grows the host count by exactly one
    a_host_grow: assert property (@(posedge clk) disable iff (!rst_n)
        tctl.host_wr |=> (host_used_reg == $past(host_used_reg) + HCNT_W'(1)))
        else $error("host fill count not advanced");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/iprtm_tables.sv
// ----------------------------------------------------------------------------
// iprtm_tables
// Host and network rule memories, one write and one registered read each.
// ----------------------------------------------------------------------------
`default_nettype none

module iprtm_tables #(
    parameter int HOST_ENTRIES = 64,
    parameter int NET_ENTRIES  = 32,
    localparam int HIDX_W = $clog2(HOST_ENTRIES > 1 ? HOST_ENTRIES : 2),
    localparam int NIDX_W = $clog2(NET_ENTRIES > 1 ? NET_ENTRIES : 2)
) (
    input  wire logic                  clk,
    input  wire iprtm_pkg::tbl_ctrl_t  ctl,
    input  wire logic [HIDX_W-1:0]     host_rd_addr,
    input  wire logic [HIDX_W-1:0]     host_wr_addr,
    input  wire iprtm_pkg::host_entry_t host_wr_data,
    output iprtm_pkg::host_entry_t     host_rd_data,
    input  wire logic [NIDX_W-1:0]     net_rd_addr,
    input  wire logic [NIDX_W-1:0]     net_wr_addr,
    input  wire iprtm_pkg::net_entry_t net_wr_data,
    output iprtm_pkg::net_entry_t      net_rd_data
);
    import iprtm_pkg::*;

    host_entry_t host_mem [HOST_ENTRIES];
    net_entry_t  net_mem  [NET_ENTRIES];
    host_entry_t host_rd_reg;
    net_entry_t  net_rd_reg;

    // host store, read data held while no read is issued
    always_ff @(posedge clk)
    begin
        if (ctl.host_wr)
            host_mem[host_wr_addr] <= host_wr_data;
        if (ctl.host_rd)
            host_rd_reg <= host_mem[host_rd_addr];
    end

    // network store
    always_ff @(posedge clk)
    begin
        if (ctl.net_wr)
            net_mem[net_wr_addr] <= net_wr_data;
        if (ctl.net_rd)
            net_rd_reg <= net_mem[net_rd_addr];
    end

    assign host_rd_data = host_rd_reg;
    assign net_rd_data  = net_rd_reg;

endmodule

`default_nettype wire

FILE: tb/tb_ip_rule_table_match_core.sv
// ----------------------------------------------------------------------------
// tb_ip_rule_table_match_core
// Self-checking bench for the IPv4 rule table: inserts, first-match and
// collect-all lookups are streamed in with random gaps and output stalls,
// and every result item is checked against a behavioral copy of the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ip_rule_table_match_core;

    import iprtm_pkg::*;

    localparam int HOST_DEPTH   = 64;
    localparam int NET_DEPTH    = 32;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 200;
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 1000000;

    // codes not named in the package
    localparam req_t     REQ_IGNORED = 2'd3;
    localparam action_t  ACT_NEG     = 2'd1;
    localparam action_t  ACT_NONE    = 2'd2;
    localparam verdict_t VERD_NEG    = 2'd2;

    typedef struct packed {
        status_t             status;
        verdict_t            verdict;
        logic [ADDR_W-1:0]   network;
        logic [PREFIX_W-1:0] prefix;
        logic                last;
    } rule_result_t;

    // behavioral copy of the rule table plus the queue of awaited results
    class rule_table_scoreboard;
        logic [ADDR_W-1:0]   host_addr [HOST_DEPTH];
        action_t             host_act  [HOST_DEPTH];
        logic [ADDR_W-1:0]   net_addr  [NET_DEPTH];
        logic [PREFIX_W-1:0] net_pre   [NET_DEPTH];
        action_t             net_act   [NET_DEPTH];
        int                  host_cnt    = 0;
        int                  net_cnt     = 0;
        bit                  enable_q    = 1'b1;
        bit                  reject_q    = 1'b0;
        int                  mismatches  = 0;
        rule_result_t        due_results[$];

        function logic [ADDR_W-1:0] prefix_bits(logic [PREFIX_W-1:0] p);
            return ~({ADDR_W{1'b1}} >> int'(p));
        endfunction

        function verdict_t action_verdict(action_t a);
            case (a)
                ACT_POS: return VERD_POS;
                ACT_NEG: return VERD_NEG;
                default: return VERD_NEITHER;
            endcase
        endfunction

        function rule_result_t result_of(status_t st, verdict_t vd,
                                         logic [ADDR_W-1:0] net,
                                         logic [PREFIX_W-1:0] pre, logic last);
            rule_result_t r;
            r.status  = st;
            r.verdict = vd;
            r.network = net;
            r.prefix  = pre;
            r.last    = last;
            return r;
        endfunction

        function void write_config(logic [CFG_INDEX_W-1:0] idx, bit val);
            if (idx == CFG_ENABLE)
                enable_q = val;
            else
                reject_q = val;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void predict_insert(logic [ADDR_W-1:0] addr,
                                     logic [PREFIX_W-1:0] plen, action_t act);
            logic [PREFIX_W-1:0] p;
            logic [ADDR_W-1:0]   net;
            bit                  dup;
            status_t             st;
            int                  i;
            p   = (plen > PREFIX_HOST) ? PREFIX_HOST : plen;
            net = addr & prefix_bits(p);
            dup = 1'b0;
            st  = STAT_OK;
            if (p == PREFIX_HOST)
            begin
                for (i = 0; i < host_cnt; i++)
                    if (host_addr[i] == net)
                        dup = 1'b1;
                if (dup)
                    st = reject_q ? STAT_DUP_ERR : STAT_DUP_IGN;
                else if (host_cnt >= HOST_DEPTH)
                    st = STAT_FULL;
                else
                begin
                    host_addr[host_cnt] = net;
                    host_act[host_cnt]  = act;
                    host_cnt++;
                end
            end
            else
            begin
                for (i = 0; i < net_cnt; i++)
                    if (net_addr[i] == net && net_pre[i] == p)
                        dup = 1'b1;
                if (dup)
                    st = reject_q ? STAT_DUP_ERR : STAT_DUP_IGN;
                else if (net_cnt >= NET_DEPTH)
                    st = STAT_FULL;
                else
                begin
                    net_addr[net_cnt] = net;
                    net_pre[net_cnt]  = p;
                    net_act[net_cnt]  = act;
                    net_cnt++;
                end
            end
            due_results.push_back(result_of(st, VERD_NONE, net, p, 1'b1));
        endfunction

        function void predict_lookup(req_t req, logic [ADDR_W-1:0] addr);
            rule_result_t hits[$];
            rule_result_t r;
            bit           found;
            int           i;
            found = 1'b0;
            // disabled or empty table answers no match
            if (!enable_q || (host_cnt == 0 && net_cnt == 0))
            begin
                due_results.push_back(result_of(STAT_OK, VERD_NONE, '0, '0, 1'b1));
                return;
            end
            if (req == REQ_FIRST)
            begin
                // exact host first, then networks newest to oldest
                for (i = 0; i < host_cnt && !found; i++)
                    if (host_addr[i] == addr)
                    begin
                        hits.push_back(result_of(STAT_OK, action_verdict(host_act[i]),
                                                 addr, PREFIX_HOST, 1'b1));
                        found = 1'b1;
                    end
                for (i = net_cnt - 1; i >= 0 && !found; i--)
                    if ((addr & prefix_bits(net_pre[i])) == net_addr[i])
                    begin
                        hits.push_back(result_of(STAT_OK, action_verdict(net_act[i]),
                                                 net_addr[i], net_pre[i], 1'b1));
                        found = 1'b1;
                    end
            end
            else
            begin
                // every positive entry: host, then networks newest to oldest
                for (i = 0; i < host_cnt && !found; i++)
                    if (host_addr[i] == addr && host_act[i] == ACT_POS)
                    begin
                        hits.push_back(result_of(STAT_OK, VERD_POS, addr, PREFIX_HOST,
                                                 1'b0));
                        found = 1'b1;
                    end
                for (i = net_cnt - 1; i >= 0; i--)
                    if (net_act[i] == ACT_POS &&
                        (addr & prefix_bits(net_pre[i])) == net_addr[i])
                        hits.push_back(result_of(STAT_OK, VERD_POS, net_addr[i],
                                                 net_pre[i], 1'b0));
            end
            if (hits.size() == 0)
                hits.push_back(result_of(STAT_OK, VERD_NONE, '0, '0, 1'b1));
            for (i = 0; i < hits.size(); i++)
            begin
                r = hits[i];
                r.last = (i == hits.size() - 1);
                due_results.push_back(r);
            end
        endfunction

        function void note_request(req_t req, logic [ADDR_W-1:0] addr,
                                   logic [PREFIX_W-1:0] plen, action_t act);
            case (req)
                REQ_INSERT: predict_insert(addr, plen, act);
                REQ_FIRST,
                REQ_ALL:    predict_lookup(req, addr);
                default:    ;
            endcase
        endfunction

        function void check_result(rule_result_t got);
            rule_result_t want;
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t unexpected result: st=%0d vd=%0d net=%h pre=%0d last=%0b",
                             $realtime, got.status, got.verdict, got.network, got.prefix,
                             got.last);
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status || got.verdict !== want.verdict ||
                got.network !== want.network || got.prefix !== want.prefix ||
                got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t mismatch: expected st=%0d vd=%0d net=%h pre=%0d last=%0b, %s",
                             $realtime, want.status, want.verdict, want.network,
                             want.prefix, want.last,
                             $sformatf("got st=%0d vd=%0d net=%h pre=%0d last=%0b",
                                       got.status, got.verdict, got.network,
                                       got.prefix, got.last));
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic [S_TDATA_W-1:0]      s_axis_tdata;
    logic [1:0]                s_axis_tuser;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [M_TDATA_W-1:0]      m_axis_tdata;
    logic                      m_axis_tlast;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic                      cfg_we;
    logic [CFG_INDEX_W-1:0]    cfg_index;
    logic                      cfg_data;

    rule_table_scoreboard      sb;
    rule_result_t              seen_result;
    bit                        src_stall;
    bit                        snk_stall;
    bit                        hold_flag;
    int                        cycles;
    logic [ADDR_W-1:0]         bases[$];
    logic [ADDR_W-1:0]         rule_addr[$];
    logic [PREFIX_W-1:0]       rule_pre[$];

    ip_rule_table_match_core #(
        .HOST_ENTRIES (HOST_DEPTH),
        .NET_ENTRIES  (NET_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // result sink: random stall bursts, plus one long hold on request
    initial
    begin
        int burst;
        bit held;
        burst = 0;
        held  = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_flag && !held)
            begin
                m_axis_tready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                held  = 1'b1;
                burst = 0;
            end
            else
            begin
                if (burst == 0 && snk_stall && $urandom_range(0, 5) == 0)
                    burst = $urandom_range(1, 9);
                if (burst > 0)
                begin
                    m_axis_tready = 1'b0;
                    burst--;
                end
                else
                    m_axis_tready = 1'b1;
            end
        end
    end

    // check every accepted result item
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
        begin
            seen_result.status  = m_axis_tdata[1:0];
            seen_result.verdict = m_axis_tdata[3:2];
            seen_result.network = m_axis_tdata[35:4];
            seen_result.prefix  = m_axis_tdata[41:36];
            seen_result.last    = m_axis_tlast;
            sb.check_result(seen_result);
        end
    end

    // one request item, with an optional idle burst ahead of it
    task automatic send_item(input req_t req, input logic [ADDR_W-1:0] addr,
                             input logic [PREFIX_W-1:0] plen, input action_t act);
        int gap;
        if (src_stall && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tdata  = {act, plen, addr};
        s_axis_tuser  = req;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        sb.note_request(req, addr, plen, act);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input bit val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
        sb.write_config(idx, val);
    endtask

    // stop offering, wait for all results, then let the walk finish
    task automatic settle_table();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic action_t random_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return ACT_POS;
        else if (r < 75)
            return ACT_NEG;
        else if (r < 92)
            return ACT_NONE;
        return ACT_ODD;
    endfunction

    // address close to one of the base networks, so rules nest and overlap
    function automatic logic [ADDR_W-1:0] near_base();
        return bases[$urandom_range(0, bases.size() - 1)] ^
               ($urandom >> $urandom_range(4, 31));
    endfunction

    // new rule of the given kind, mostly positive to grow collect-all lists
    task automatic send_fresh(input bit host);
        logic [ADDR_W-1:0]   a;
        logic [PREFIX_W-1:0] p;
        action_t             ac;
        if (host)
        begin
            a = $urandom;
            p = PREFIX_HOST;
        end
        else
        begin
            a = near_base();
            p = PREFIX_W'($urandom_range(1, 31));
        end
        ac = ($urandom_range(0, 9) < 7) ? ACT_POS : random_action();
        rule_addr.push_back(a);
        rule_pre.push_back(p);
        send_item(REQ_INSERT, a, p, ac);
    endtask

    // one random item; counted is low for an ignored request kind
    task automatic send_random(output bit counted);
        req_t                rq;
        logic [ADDR_W-1:0]   a;
        logic [PREFIX_W-1:0] p;
        logic [PREFIX_W-1:0] pc;
        action_t             ac;
        int                  r;
        int                  s;
        int                  k;
        r  = $urandom_range(0, 99);
        a  = $urandom;
        p  = PREFIX_W'($urandom_range(0, 63));
        ac = random_action();
        if (r < 4)
            rq = REQ_IGNORED;
        else if (r < 48)
        begin
            rq = REQ_INSERT;
            s  = $urandom_range(0, 99);
            if (s < 15 && rule_addr.size() > 0)
            begin
                // same rule again, host bits scrambled
                k  = $urandom_range(0, rule_addr.size() - 1);
                p  = rule_pre[k];
                pc = (p > PREFIX_HOST) ? PREFIX_HOST : p;
                a  = rule_addr[k] | ($urandom & ~sb.prefix_bits(pc));
            end
            else
            begin
                if (s < 45)
                    p = ($urandom_range(0, 4) == 0) ? PREFIX_W'($urandom_range(33, 63))
                                                    : PREFIX_HOST;
                else
                begin
                    p = ($urandom_range(0, 20) == 0) ? '0
                                                     : PREFIX_W'($urandom_range(1, 31));
                    a = near_base();
                end
                rule_addr.push_back(a);
                rule_pre.push_back(p);
            end
        end
        else
        begin
            rq = (r < 78) ? REQ_FIRST : REQ_ALL;
            s  = $urandom_range(0, 99);
            if (s < 35 && rule_addr.size() > 0)
            begin
                k  = $urandom_range(0, rule_addr.size() - 1);
                pc = (rule_pre[k] > PREFIX_HOST) ? PREFIX_HOST : rule_pre[k];
                a  = rule_addr[k] ^ ($urandom & ~sb.prefix_bits(pc));
            end
            else if (s < 75)
                a = near_base();
        end
        counted = (rq != REQ_IGNORED);
        send_item(rq, a, p, ac);
    endtask

    // main sequence
    initial
    begin
        int n;
        int i;
        int extra;
        bit counted;
        sb            = new;
        rst_n         = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tvalid = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = 1'b0;
        src_stall     = 1'b0;
        snk_stall     = 1'b0;
        hold_flag     = 1'b0;
        for (i = 0; i < 6; i++)
            bases.push_back($urandom);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (4) @(negedge clk);
        write_reg(CFG_ENABLE, 1'b1);
        write_reg(CFG_REJECT, 1'b0);

        // directed: empty table, ignored kind, host and network rules
        send_item(REQ_FIRST,   32'h0A00_0001, 6'd0,  ACT_POS);
        send_item(REQ_ALL,     32'hFFFF_FFFF, 6'd63, ACT_ODD);
        send_item(REQ_IGNORED, 32'hFFFF_FFFF, 6'd63, ACT_ODD);
        send_item(REQ_INSERT,  32'h0A00_0001, 6'd32, ACT_POS);
        send_item(REQ_INSERT,  32'h0A00_0002, 6'd40, ACT_ODD);
        send_item(REQ_INSERT,  32'hFFFF_FFFF, 6'd63, ACT_NEG);
        send_item(REQ_INSERT,  32'h0A01_0203, 6'd8,  ACT_POS);
        send_item(REQ_INSERT,  32'h0A01_FFFF, 6'd16, ACT_NEG);
        send_item(REQ_INSERT,  32'hDEAD_BEEF, 6'd0,  ACT_NONE);
        send_item(REQ_INSERT,  32'h0A01_0203, 6'd24, ACT_POS);
        // duplicates, ignored
        send_item(REQ_INSERT,  32'h0A00_0001, 6'd32, ACT_NEG);
        send_item(REQ_INSERT,  32'h0A09_0909, 6'd8,  ACT_NEG);
        // first match: host, odd action, newest net, then two catch-all hits
        send_item(REQ_FIRST,   32'h0A00_0001, 6'd0,  ACT_POS);
        send_item(REQ_FIRST,   32'h0A00_0002, 6'd0,  ACT_POS);
        send_item(REQ_FIRST,   32'h0A01_0203, 6'd0,  ACT_POS);
        send_item(REQ_FIRST,   32'h0A01_FF00, 6'd0,  ACT_POS);
        send_item(REQ_FIRST,   32'h0B00_0000, 6'd0,  ACT_POS);
        // collect all
        send_item(REQ_ALL,     32'h0A01_0203, 6'd0,  ACT_POS);
        send_item(REQ_ALL,     32'h0A00_0001, 6'd0,  ACT_POS);
        send_item(REQ_ALL,     32'hC0A8_0001, 6'd0,  ACT_POS);
        send_item(REQ_FIRST,   32'h0000_0000, 6'd0,  ACT_POS);
        settle_table();

        // duplicates reported as errors
        write_reg(CFG_REJECT, 1'b1);
        send_item(REQ_INSERT,  32'h0A00_0001, 6'd32, ACT_POS);
        send_item(REQ_INSERT,  32'h0A01_0299, 6'd24, ACT_POS);
        settle_table();

        // disabled: lookups miss, inserts still land
        write_reg(CFG_ENABLE, 1'b0);
        send_item(REQ_FIRST,   32'h0A00_0001, 6'd0,  ACT_POS);
        send_item(REQ_INSERT,  32'h0A00_0003, 6'd32, ACT_POS);
        settle_table();
        write_reg(CFG_ENABLE, 1'b1);
        write_reg(CFG_REJECT, 1'b0);

        // random traffic with idle bursts on both sides
        src_stall = 1'b1;
        snk_stall = 1'b1;
        n = 0;
        while (n < 70)
        begin
            send_random(counted);
            if (counted)
                n++;
        end
        settle_table();
        write_reg(CFG_REJECT, 1'b1);

        // sink holds off while requests keep coming, then a full drain
        hold_flag = 1'b1;
        for (i = 0; i < 12; i++)
            send_random(counted);
        settle_table();

        // fill both stores past capacity, with lookups mixed in
        extra = 0;
        n = 0;
        while (sb.host_cnt < HOST_DEPTH || sb.net_cnt < NET_DEPTH || extra < 6)
        begin
            if (sb.host_cnt < HOST_DEPTH &&
                (sb.net_cnt >= NET_DEPTH || $urandom_range(0, 1) == 1))
                send_fresh(1'b1);
            else if (sb.net_cnt < NET_DEPTH)
                send_fresh(1'b0);
            else
            begin
                send_fresh(1'($urandom_range(0, 1)));
                extra++;
            end
            n++;
            if (n % 3 == 0)
                send_random(counted);
        end
        settle_table();

        // disabled table with random traffic
        write_reg(CFG_ENABLE, 1'b0);
        n = 0;
        while (n < 20)
        begin
            send_random(counted);
            if (counted)
                n++;
        end
        settle_table();

        // final stretch without idling
        write_reg(CFG_ENABLE, 1'b1);
        write_reg(CFG_REJECT, 1'b0);
        src_stall = 1'b0;
        snk_stall = 1'b0;
        n = 0;
        while (n < 50)
        begin
            send_random(counted);
            if (counted)
                n++;
        end
        settle_table();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
